// File: design/fcks_pkg.sv
package fcks_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int CAP_W        = 5;
  localparam int CNT_OUT_W    = 5;
  localparam int QDEPTH       = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef struct packed {
    status_t                status;
    logic                   found;
    logic [CNT_OUT_W-1:0]   key_count;
  } result_t;

endpackage

// File: design/fcks_if.sv
interface fcks_in_if #(
  parameter int KEY_BITS = fcks_pkg::KEY_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface fcks_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic                           found;
  logic [fcks_pkg::CNT_OUT_W-1:0] key_count;

  modport source (output valid, output status, output found, output key_count, input ready);
  modport sink   (input valid, input status, input found, input key_count, output ready);
endinterface

// File: design/fcks_ram.sv
module fcks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: design/fcks_queue.sv
module fcks_queue #(
  parameter int WIDTH = 34,
  parameter int DEPTH = fcks_pkg::QDEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/fcks_front.sv
module fcks_front #(
  parameter int KEY_BITS = fcks_pkg::KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  fcks_in_if.sink             in_ch,
  output logic                push_valid,
  input  logic                push_ready,
  output fcks_pkg::op_t       push_op,
  output logic [KEY_BITS-1:0] push_key
);

  logic                hold_v_r, hold_v_nxt;
  fcks_pkg::op_t       hold_op_r;
  logic [KEY_BITS-1:0] hold_key_r;
  fcks_pkg::op_t       op_class;
  logic                take;

  assign in_ch.ready = !hold_v_r || push_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign push_valid  = hold_v_r;
  assign push_op     = hold_op_r;
  assign push_key    = hold_key_r;

  // the unused opcode behaves as a membership test
  always_comb begin
    unique case (in_ch.opcode)
      fcks_pkg::OP_ADD:    op_class = fcks_pkg::OP_ADD;
      fcks_pkg::OP_REMOVE: op_class = fcks_pkg::OP_REMOVE;
      default:             op_class = fcks_pkg::OP_CONTAINS;
    endcase
  end

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (take) begin
      hold_v_nxt = 1'b1;
    end else if (push_ready) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_op_r  <= op_class;
      hold_key_r <= in_ch.key;
    end
  end

endmodule

// File: design/fcks_back.sv
module fcks_back #(
  parameter int SLOTS    = fcks_pkg::SLOTS_DEF,
  parameter int KEY_BITS = fcks_pkg::KEY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [fcks_pkg::CAP_W-1:0] cap,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  fcks_pkg::op_t              q_op,
  input  logic [KEY_BITS-1:0]        q_key,
  output logic                       res_valid,
  input  logic                       res_ready,
  output fcks_pkg::result_t          res
);

  localparam int IDX_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CW    = CNT_W > fcks_pkg::CAP_W ? CNT_W : fcks_pkg::CAP_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

  state_t              state_r, state_nxt;
  fcks_pkg::op_t       op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]    last_r, last_nxt;
  logic [IDX_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]    chk_idx_r, chk_idx_nxt;
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic                free_r, free_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic [SLOTS-1:0]    valid_r, valid_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                res_valid_r, res_valid_nxt;
  fcks_pkg::result_t   res_r, res_nxt;

  logic [CW-1:0]       cap_ext, lim_ext, cnt_ext;
  logic [IDX_W-1:0]    last_idx;
  logic [KEY_BITS-1:0] ram_rdata;
  logic                ram_we;
  logic                slot_v, match, empty;
  logic                load_res;
  fcks_pkg::status_t   done_status;

  fcks_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (key_r),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  // clamp capacity into 1..SLOTS
  assign cap_ext  = CW'(cap);
  assign lim_ext  = (cap_ext == '0) ? CW'(1) :
                    (cap_ext > CW'(SLOTS)) ? CW'(SLOTS) : cap_ext;
  assign last_idx = IDX_W'(lim_ext - CW'(1));

  assign slot_v = valid_r[chk_idx_r];
  assign match  = chk_v_r && slot_v && (ram_rdata == key_r);
  assign empty  = chk_v_r && !slot_v;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    scan_idx_nxt  = scan_idx_r;
    chk_v_nxt     = 1'b0;
    chk_idx_nxt   = scan_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    valid_nxt     = valid_r;
    cnt_nxt       = cnt_r;
    res_valid_nxt = res_valid_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    load_res      = 1'b0;
    done_status   = fcks_pkg::ST_OK;

    if (res_valid_r && res_ready) begin
      res_valid_nxt = 1'b0;
    end

    // keep only the lowest matching slot and the lowest free slot
    if (match && !hit_r) begin
      hit_nxt     = 1'b1;
      hit_idx_nxt = chk_idx_r;
    end
    if (empty && !free_r) begin
      free_nxt     = 1'b1;
      free_idx_nxt = chk_idx_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          op_nxt       = q_op;
          key_nxt      = q_key;
          last_nxt     = last_idx;
          hit_nxt      = 1'b0;
          free_nxt     = 1'b0;
          chk_v_nxt    = 1'b1;
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
          state_nxt    = (last_idx == '0) ? S_DRAIN : S_SCAN;
        end
      end
      S_SCAN: begin
        chk_v_nxt    = 1'b1;
        scan_idx_nxt = scan_idx_r + IDX_W'(1);
        if (scan_idx_r == last_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!res_valid_r || res_ready) begin
          load_res      = 1'b1;
          res_valid_nxt = 1'b1;
          scan_idx_nxt  = '0;
          state_nxt     = S_IDLE;
          case (op_r)
            fcks_pkg::OP_ADD: begin
              if (hit_r) begin
                done_status = fcks_pkg::ST_DUP;
              end else if (free_r) begin
                ram_we                = 1'b1;
                valid_nxt[free_idx_r] = 1'b1;
                cnt_nxt               = cnt_r + CNT_W'(1);
                done_status           = fcks_pkg::ST_OK;
              end else begin
                done_status = fcks_pkg::ST_FULL;
              end
            end
            fcks_pkg::OP_REMOVE: begin
              if (hit_r) begin
                valid_nxt[hit_idx_r] = 1'b0;
                if (cnt_r != '0) begin
                  cnt_nxt = cnt_r - CNT_W'(1);
                end
                done_status = fcks_pkg::ST_OK;
              end else begin
                done_status = fcks_pkg::ST_MISS;
              end
            end
            default: begin
              done_status = hit_r ? fcks_pkg::ST_OK : fcks_pkg::ST_MISS;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cnt_ext = CW'(cnt_nxt);

  always_comb begin
    res_nxt.status    = done_status;
    res_nxt.found     = hit_r;
    res_nxt.key_count = cnt_ext[fcks_pkg::CNT_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_idx_r  <= '0;
      chk_v_r     <= 1'b0;
      valid_r     <= '0;
      cnt_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_idx_r  <= scan_idx_nxt;
      chk_v_r     <= chk_v_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    last_r     <= last_nxt;
    chk_idx_r  <= chk_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    if (load_res) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// File: design/fixed_capacity_key_set.sv
// Set of up to SLOTS keys with add, remove and membership test.
// in_ch carries opcode (0 add, 1 remove, 2 or 3 membership test) and key;
// out_ch returns one result per item: status (0 ok, 1 already present,
// 2 full, 3 not found), found (key present before the operation) and
// key_count (keys held after it). cfg_we/cfg_wdata write the capacity,
// clamped to 1..SLOTS; write it only while the block is idle.
// An input register and a two-entry queue feed a sequencer that walks the
// slots one per cycle through the single read port of the key RAM, then
// updates the store and loads the result register.
// The sequencer takes a new item only once the result of the last is loaded,
// so its rate is set by the clamped capacity through that one-slot-per-cycle scan.
// Reset empties the store, clears the count and sets capacity to 16; it
// takes effect at once, with no clearing pass.
// While out_ch is stalled the result is held; the sequencer finishes its
// current scan and waits, and the queue and input register take up to
// three more items before in_ch.ready drops.
module fixed_capacity_key_set #(
  parameter int SLOTS    = fcks_pkg::SLOTS_DEF,
  parameter int KEY_BITS = fcks_pkg::KEY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  fcks_in_if.sink                    in_ch,
  fcks_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [fcks_pkg::CAP_W-1:0] cfg_wdata
);

  logic [fcks_pkg::CAP_W-1:0] cap_r;
  logic                       push_valid, push_ready;
  fcks_pkg::op_t              push_op;
  logic [KEY_BITS-1:0]        push_key;
  logic                       q_valid, q_pop;
  logic [KEY_BITS+1:0]        q_data;
  fcks_pkg::result_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= fcks_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  fcks_front #(.KEY_BITS(KEY_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .push_key   (push_key)
  );

  fcks_queue #(.WIDTH(KEY_BITS + 2), .DEPTH(fcks_pkg::QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_op, push_key}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  fcks_back #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap       (cap_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_op      (fcks_pkg::op_t'(q_data[KEY_BITS+1:KEY_BITS])),
    .q_key     (q_data[KEY_BITS-1:0]),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.status    = res.status;
  assign out_ch.found     = res.found;
  assign out_ch.key_count = res.key_count;

  a_dup_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == fcks_pkg::ST_DUP) |-> out_ch.found)
    else $error("duplicate reported for a key that was not found");

  a_miss_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == fcks_pkg::ST_FULL ||
                      out_ch.status == fcks_pkg::ST_MISS)) |-> !out_ch.found)
    else $error("full or not-found reported for a found key");

  a_full_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == fcks_pkg::ST_FULL) |->
      (SLOTS >= 32 || out_ch.key_count != '0))
    else $error("store reported full while holding no keys");

  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("sequencer popped an empty queue");

endmodule
